### hdl/rssq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rssq_pkg;

  localparam int MAX_PIXELS   = 16384;
  localparam int MAX_CHANNELS = 32;
  localparam int SAMPLE_W     = 16;
  localparam int PIX_W        = $clog2(MAX_PIXELS);
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int NCH_W        = 6;
  localparam int NPIX_W       = 15;
  localparam int CFG_W        = 15;
  localparam int PROD_W       = 2 * SAMPLE_W;
  localparam int SQ_W         = 2 * SAMPLE_W - 1;
  localparam int SUM_W        = 37;
  localparam int RAD_W        = 38;
  localparam int MAG_W        = 19;
  localparam int ROOT_STEPS   = RAD_W / 2;
  localparam int STEP_W       = 5;
  localparam int REM_W        = MAG_W + 3;
  localparam int IN_W         = 2 * SAMPLE_W;
  localparam int OUT_W        = 24;

  typedef enum logic {
    REG_NUM_CHANNELS = 1'b0,
    REG_NUM_PIXELS   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic square;
    logic accum;
    logic root_step;
    logic out_load;
  } rssq_cmd_t;

  typedef struct packed {
    logic last_channel;
    logic root_last;
    logic out_busy;
  } rssq_status_t;

endpackage
`default_nettype wire

### hdl/rssq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rssq_ctrl import rssq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire rssq_status_t status,
  output rssq_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_ROOT,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.square    = (state == S_SQUARE);
    cmd.accum     = (state == S_ACCUM);
    cmd.root_step = (state == S_ROOT);
    cmd.out_load  = (state == S_FINISH) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SQUARE;
        end
        S_SQUARE: state <= S_ACCUM;
        S_ACCUM: begin
          state <= status.last_channel ? S_ROOT : S_IDLE;
        end
        S_ROOT: begin
          if (status.root_last) state <= S_FINISH;
        end
        S_FINISH: begin
          // wait for the output register to free up
          if (!status.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/rssq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rssq_datapath import rssq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rssq_cmd_t            cmd,
  output rssq_status_t              status,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [SAMPLE_W-1:0]  sample_re,
  input  wire logic [SAMPLE_W-1:0]  sample_im,
  output logic [MAG_W-1:0]          magnitude,
  output logic                      frame_end,
  output logic                      out_valid,
  input  wire logic                 out_ready
);

  logic [NCH_W-1:0]  num_channels;
  logic [NPIX_W-1:0] num_pixels;
  logic [PIX_W-1:0]  pixel_position;
  logic [CH_W-1:0]   channel_position;

  logic [NCH_W-1:0]  nch_m1;
  logic [NPIX_W-1:0] npix_m1;
  logic [CH_W-1:0]   last_ch_idx;
  logic [PIX_W-1:0]  last_px_idx;
  logic [PIX_W-1:0]  px_eff;
  logic              is_last_px;
  logic              is_last_ch;

  logic signed [SAMPLE_W-1:0] re_q;
  logic signed [SAMPLE_W-1:0] im_q;
  logic [PIX_W-1:0]  addr;
  logic              first_ch;
  logic              last_ch;
  logic              last_px;

  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic [SQ_W-1:0]   sq_re;
  logic [SQ_W-1:0]   sq_im;

  logic [SUM_W-1:0]  sums_mem [MAX_PIXELS];
  logic [SUM_W-1:0]  rd_data;
  logic [SUM_W-1:0]  base;
  logic [SUM_W-1:0]  sum_next;

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [MAG_W-1:0]  root;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // saturate the register values to the supported ranges
  always_comb begin
    nch_m1  = num_channels - NCH_W'(1);
    npix_m1 = num_pixels - NPIX_W'(1);
    if (num_channels == '0) begin
      last_ch_idx = '0;
    end else if (num_channels > NCH_W'(MAX_CHANNELS)) begin
      last_ch_idx = CH_W'(MAX_CHANNELS - 1);
    end else begin
      last_ch_idx = nch_m1[CH_W-1:0];
    end
    if (num_pixels == '0) begin
      last_px_idx = '0;
    end else if (num_pixels > NPIX_W'(MAX_PIXELS)) begin
      last_px_idx = PIX_W'(MAX_PIXELS - 1);
    end else begin
      last_px_idx = npix_m1[PIX_W-1:0];
    end
    px_eff     = (pixel_position > last_px_idx) ? last_px_idx : pixel_position;
    is_last_px = (px_eff == last_px_idx);
    is_last_ch = (channel_position >= last_ch_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels     <= NCH_W'(1);
      num_pixels       <= NPIX_W'(MAX_PIXELS);
      pixel_position   <= '0;
      channel_position <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_CHANNELS: num_channels <= cfg_data[NCH_W-1:0];
        REG_NUM_PIXELS:   num_pixels   <= cfg_data[NPIX_W-1:0];
        default: ;
      endcase
      pixel_position   <= '0;
      channel_position <= '0;
    end else if (cmd.accept) begin
      if (is_last_px) begin
        pixel_position   <= '0;
        channel_position <= is_last_ch ? '0 : channel_position + CH_W'(1);
      end else begin
        pixel_position <= px_eff + PIX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      re_q     <= sample_re;
      im_q     <= sample_im;
      addr     <= px_eff;
      first_ch <= (channel_position == '0);
      last_ch  <= is_last_ch;
      last_px  <= is_last_px;
    end
  end

  assign prod_re = re_q * re_q;
  assign prod_im = im_q * im_q;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_re <= prod_re[SQ_W-1:0];
      sq_im <= prod_im[SQ_W-1:0];
    end
  end

  // per-pixel power sums, read during the square cycle, written back on accumulate
  assign base     = first_ch ? '0 : rd_data;
  assign sum_next = base + SUM_W'(sq_re) + SUM_W'(sq_im);

  always_ff @(posedge clk) begin
    if (cmd.accum) sums_mem[addr] <= sum_next;
    if (cmd.square) rd_data <= sums_mem[addr];
  end

  // restoring square root, two radicand bits per step
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      rad  <= RAD_W'(sum_next);
      rem  <= '0;
      root <= '0;
      step <= '0;
    end else if (cmd.root_step) begin
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[MAG_W-2:0], 1'b0};
      end
      rad  <= {rad[RAD_W-3:0], 2'b00};
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      magnitude <= root;
      frame_end <= last_px;
    end
  end

  always_comb begin
    status              = '0;
    status.last_channel = last_ch;
    status.root_last    = (step == STEP_W'(ROOT_STEPS - 1));
    status.out_busy     = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

### hdl/root_sum_of_squares_coil_combine.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | payload
// s_axis   | in        | tdata: sample_re[15:0], sample_im[31:16]
// m_axis   | out       | tdata: magnitude[18:0], zero fill; tlast: frame_end
// cfg      | in        | cfg_index 0 num_channels, 1 num_pixels
//
// a sample of a channel before the last passes accept, square and memory read,
// then accumulate and write back to the per-pixel sum memory.
// on the last channel the bit-pair square root follows, then the output
// register is loaded in the finish state; no new sample is taken before idle.
// a stalled output holds the next result in the finish state, input stays closed.
// rst is synchronous; the sum memory is not cleared, channel 0 overwrites it.
module root_sum_of_squares_coil_combine import rssq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,   // sample_re, sample_im
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // magnitude, zero fill
  output logic                   m_tlast,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  rssq_cmd_t        cmd;
  rssq_status_t     status;
  logic [MAG_W-1:0] magnitude;

  rssq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rssq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_re (s_tdata[SAMPLE_W-1:0]),
    .sample_im (s_tdata[IN_W-1:SAMPLE_W]),
    .magnitude (magnitude),
    .frame_end (m_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = OUT_W'(magnitude);

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register loaded while holding an untaken result");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.square, cmd.accum, cmd.root_step, cmd.out_load}))
    else $error("more than one datapath command at once");
`endif

endmodule
`default_nettype wire
